// ----- design/gld_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_pkg
// Shared types and constants of the gas level detector: field widths,
// register codes and reset values, and the words passed between stages.
// ---------------------------------------------------------------------------
package gld_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = 4095;
    localparam int THR_W      = 13;
    // running total holds up to 4095 * 64
    localparam int TOTAL_W    = 18;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_DATA_W-1:0] THR_OFFSET_RST = 12'd200;
    localparam logic [CFG_DATA_W-1:0] HYST_WIDTH_RST = 12'd50;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [THR_W-1:0]    t_thr;
    typedef logic [TOTAL_W-1:0]  t_total;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_OFFSET = 1'b0,
        CFG_HYST_WIDTH = 1'b1
    } t_cfg_idx;

    // window stage -> detect stage
    typedef struct packed {
        logic    calib;
        t_sample base;
        t_total  total;
    } t_win_word;

    // one result word
    typedef struct packed {
        logic    calibrating;
        t_sample average;
        t_sample baseline_level;
        t_thr    threshold_level;
        logic    detected;
        logic    alarm_raised;
    } t_result;

endpackage

// ----- design/gld_smp_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_smp_if
// Sample channel: valid/ready handshake carrying one converter reading.
// ---------------------------------------------------------------------------
interface gld_smp_if;

    logic             valid;
    logic             ready;
    gld_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// ----- design/gld_res_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_res_if
// Result channel: valid/ready handshake carrying one detector result word.
// ---------------------------------------------------------------------------
interface gld_res_if;

    logic             valid;
    logic             ready;
    logic             calibrating;
    gld_pkg::t_sample average;
    gld_pkg::t_sample baseline_level;
    gld_pkg::t_thr    threshold_level;
    logic             detected;
    logic             alarm_raised;

    modport source (
        output valid, output calibrating, output average, output baseline_level,
        output threshold_level, output detected, output alarm_raised,
        input ready
    );
    modport sink (
        input valid, input calibrating, input average, input baseline_level,
        input threshold_level, input detected, input alarm_raised,
        output ready
    );

endinterface

// ----- design/gld_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module gld_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 10
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/gld_cdiv.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_cdiv
// Unsigned division by a constant: multiply by a rounded-up reciprocal
// and shift. Exact for every dividend of IN_W bits whose quotient fits in OUT_W bits.
// ---------------------------------------------------------------------------
module gld_cdiv #(
    parameter int DIVISOR = 10,
    parameter int IN_W    = 18,
    parameter int OUT_W   = 12
) (
    input  logic [IN_W-1:0]  i_dividend,
    output logic [OUT_W-1:0] o_quotient
);

    localparam int SHIFT = IN_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = (IN_W + RECIP_W > SHIFT + OUT_W) ?
                             (IN_W + RECIP_W) : (SHIFT + OUT_W);

    logic [PROD_W-1:0] w_prod;

    // reciprocal product, quotient sits above the shift point
    assign w_prod     = PROD_W'(i_dividend) * PROD_W'(RECIP);
    assign o_quotient = w_prod[SHIFT +: OUT_W];

endmodule

// ----- design/gld_window.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_window
// Calibration accumulator and moving-average window. Sums the first
// samples into a baseline, then keeps a running total over a ring of
// recent samples held in RAM.
// ---------------------------------------------------------------------------
module gld_window #(
    parameter int WINDOW           = 10,
    parameter int BASELINE_SAMPLES = 50
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  gld_pkg::t_sample   i_sample,
    output gld_pkg::t_win_word o_word
);

    import gld_pkg::*;

    localparam int CS_W  = $clog2(SAMPLE_MAX * BASELINE_SAMPLES + 1);
    localparam int CC_W  = $clog2(BASELINE_SAMPLES + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [CS_W-1:0]  r_sum, n_sum;
    logic [CC_W-1:0]  r_cnt, n_cnt;
    t_sample          r_base, n_base;
    t_total           r_total, n_total;
    logic [IDX_W-1:0] r_widx, n_widx;
    logic             r_wrapped, n_wrapped;
    logic             r_first, n_first;
    logic             r_byp, n_byp;
    t_sample          r_byp_data;
    t_win_word        r_word, n_word;

    logic             w_calib;
    logic [CS_W-1:0]  w_sum_inc;
    t_sample          w_base_q;
    t_sample          w_rdata;
    t_sample          w_old;
    t_total           w_total_base;
    t_total           w_total_new;
    logic             w_last;
    logic             w_we;

    // baseline = truncated mean of the calibration samples
    gld_cdiv #(
        .DIVISOR (BASELINE_SAMPLES),
        .IN_W    (CS_W),
        .OUT_W   (SAMPLE_W)
    ) u_base_div (
        .i_dividend (w_sum_inc),
        .o_quotient (w_base_q)
    );

    // ring of recent samples; read address tracks the next write slot
    gld_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_widx),
        .i_wdata (i_sample),
        .i_raddr (n_widx),
        .o_rdata (w_rdata)
    );

    assign w_calib   = (r_cnt < CC_W'(BASELINE_SAMPLES));
    assign w_sum_inc = r_sum + CS_W'(i_sample);
    assign w_last    = (r_widx == IDX_W'(WINDOW - 1));

    // slots not yet written since calibration hold the baseline
    always_comb begin
        if (!r_wrapped) begin
            w_old = r_base;
        end else if (r_byp) begin
            w_old = r_byp_data;
        end else begin
            w_old = w_rdata;
        end
    end

    // total starts at baseline * WINDOW on the first running sample
    assign w_total_base = r_first ? (TOTAL_W'(r_base) * TOTAL_W'(WINDOW)) : r_total;
    assign w_total_new  = w_total_base - TOTAL_W'(w_old) + TOTAL_W'(i_sample);

    // next state
    always_comb begin
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_base    = r_base;
        n_total   = r_total;
        n_widx    = r_widx;
        n_wrapped = r_wrapped;
        n_first   = r_first;
        n_word    = r_word;
        w_we      = 1'b0;
        if (i_adv) begin
            if (w_calib) begin
                n_sum  = w_sum_inc;
                n_cnt  = CC_W'(r_cnt + 1'b1);
                if (r_cnt == CC_W'(BASELINE_SAMPLES - 1)) begin
                    n_base    = w_base_q;
                    n_first   = 1'b1;
                    n_widx    = '0;
                    n_wrapped = 1'b0;
                end
                n_word = '{calib: 1'b1, base: '0, total: '0};
            end else begin
                w_we    = 1'b1;
                n_total = w_total_new;
                n_first = 1'b0;
                if (w_last) begin
                    n_widx    = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_widx = IDX_W'(r_widx + 1'b1);
                end
                n_word = '{calib: 1'b0, base: r_base, total: w_total_new};
            end
        end
    end

    // read of the slot being written this cycle (one-entry window)
    assign n_byp = w_we && (n_widx == r_widx);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_cnt     <= '0;
            r_base    <= '0;
            r_widx    <= '0;
            r_wrapped <= 1'b0;
            r_first   <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_base    <= n_base;
            r_widx    <= n_widx;
            r_wrapped <= n_wrapped;
            r_first   <= n_first;
            r_byp     <= n_byp;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_word     <= n_word;
        r_byp_data <= i_sample;
    end

    assign o_word = r_word;

endmodule

// ----- design/gld_detect.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_detect
// Average, threshold and hysteresis detection. Holds the detection flag
// and the result register.
// ---------------------------------------------------------------------------
module gld_detect #(
    parameter int WINDOW = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  gld_pkg::t_win_word                  i_word,
    input  logic [gld_pkg::CFG_DATA_W-1:0]      i_thr_offset,
    input  logic [gld_pkg::CFG_DATA_W-1:0]      i_hyst_width,
    output gld_pkg::t_result                    o_result
);

    import gld_pkg::*;

    logic    r_det, n_det;
    t_result r_result, n_result;

    t_sample w_avg;
    t_thr    w_thr;
    logic    w_set;
    logic    w_clr;

    // average = total / WINDOW
    gld_cdiv #(
        .DIVISOR (WINDOW),
        .IN_W    (TOTAL_W),
        .OUT_W   (SAMPLE_W)
    ) u_avg_div (
        .i_dividend (i_word.total),
        .o_quotient (w_avg)
    );

    assign w_thr = THR_W'(i_word.base) + THR_W'(i_thr_offset);
    assign w_set = !r_det && (THR_W'(w_avg) > w_thr);
    // avg < thr - hyst, rearranged to stay unsigned
    assign w_clr = r_det &&
                   ((THR_W'(w_avg) + (THR_W + 1)'(i_hyst_width)) < (THR_W + 1)'(w_thr));

    // next flag and result
    always_comb begin
        n_det    = r_det;
        n_result = r_result;
        if (i_adv) begin
            if (i_word.calib) begin
                n_result = '{calibrating: 1'b1, average: '0, baseline_level: '0,
                             threshold_level: '0, detected: 1'b0, alarm_raised: 1'b0};
            end else begin
                if (w_set) begin
                    n_det = 1'b1;
                end else if (w_clr) begin
                    n_det = 1'b0;
                end
                n_result = '{calibrating: 1'b0, average: w_avg, baseline_level: i_word.base,
                             threshold_level: w_thr, detected: n_det, alarm_raised: w_set};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det <= 1'b0;
        end else begin
            r_det <= n_det;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

// ----- design/gas_level_detector.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gas_level_detector
// Baseline-calibrated moving-average gas detector with hysteresis.
// ---------------------------------------------------------------------------
// Path: input register, window-stage register, then result register.
// Throughput: one word per cycle unless the result channel stalls;
//   the ring RAM is read one slot ahead.
// Reset clears calibration, ring pointer, detection flag and valid bits;
//   the ring RAM is not cleared, unwritten slots read as the baseline.
// ---------------------------------------------------------------------------
module gas_level_detector #(
    parameter int WINDOW           = 10,
    parameter int BASELINE_SAMPLES = 50
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gld_smp_if.sink                            i_smp,
    gld_res_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [gld_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gld_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import gld_pkg::*;

    logic                  r_a_valid, r_b_valid, r_c_valid;
    t_sample               r_a_sample;
    logic [CFG_DATA_W-1:0] r_thr_offset, r_hyst_width;

    logic      w_adv_b, w_adv_c;
    t_win_word w_word;
    t_result   w_result;

    // pipeline flow control
    assign w_adv_c     = r_b_valid && (!r_c_valid || o_res.ready);
    assign w_adv_b     = r_a_valid && (!r_b_valid || w_adv_c);
    assign i_smp.ready = !r_a_valid || w_adv_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (i_smp.ready) begin
                r_a_valid <= i_smp.valid;
            end
            if (!r_b_valid || w_adv_c) begin
                r_b_valid <= w_adv_b;
            end
            if (!r_c_valid || o_res.ready) begin
                r_c_valid <= w_adv_c;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_a_sample <= i_smp.sample;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_offset <= THR_OFFSET_RST;
            r_hyst_width <= HYST_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THR_OFFSET: begin
                    r_thr_offset <= i_cfg_data;
                end
                CFG_HYST_WIDTH: begin
                    r_hyst_width <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    gld_window #(
        .WINDOW           (WINDOW),
        .BASELINE_SAMPLES (BASELINE_SAMPLES)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv_b),
        .i_sample (r_a_sample),
        .o_word   (w_word)
    );

    gld_detect #(
        .WINDOW (WINDOW)
    ) u_detect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv_c),
        .i_word       (w_word),
        .i_thr_offset (r_thr_offset),
        .i_hyst_width (r_hyst_width),
        .o_result     (w_result)
    );

    // result channel
    assign o_res.valid           = r_c_valid;
    assign o_res.calibrating     = w_result.calibrating;
    assign o_res.average         = w_result.average;
    assign o_res.baseline_level  = w_result.baseline_level;
    assign o_res.threshold_level = w_result.threshold_level;
    assign o_res.detected        = w_result.detected;
    assign o_res.alarm_raised    = w_result.alarm_raised;

    // a calibration word never reports detection or an average
    a_calib_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && w_result.calibrating) |-> (!w_result.detected && w_result.average == '0))
        else $error("calibration word carries detection or average");

    // an alarm only comes with the flag set
    a_alarm_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && w_result.alarm_raised) |-> w_result.detected)
        else $error("alarm without detection");

    // an empty input register always takes a word
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> i_smp.ready)
        else $error("input stalled while input register empty");

    // a stalled result word is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !o_res.ready) |=> r_c_valid)
        else $error("stalled result word lost");

endmodule

// ----- bench/gas_level_detector_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gas_level_detector_tb
// Self-checking bench for the gas level detector. A calibration table and a
// short running sequence come first. Random gas episodes follow under a
// series of offset/hysteresis settings, with random gaps on both channels.
// Every result word is checked against a cycle-free behavioral predictor.
// ---------------------------------------------------------------------------
module gas_level_detector_tb;
    import gld_pkg::*;

    localparam int WINDOW           = 10;
    localparam int BASELINE_SAMPLES = 50;
    localparam int RANDOM_SAMPLES   = 1700;
    localparam int NUM_PHASES       = 8;
    localparam int MAX_SHOWN        = 10;
    localparam int DRAIN_LIMIT      = 20000;

    // directed row: one sample value, repeated reps times
    typedef struct {
        t_sample     value;
        int unsigned reps;
        logic        typed;
        t_result     want;
    } t_stim_row;

    localparam t_result CAL_WORD = '{calibrating: 1'b1, default: '0};

    // calibration with the field extremes and alternating bits, then a full
    // swing up and down; the running rows are left to the predictor
    t_stim_row stim_table [8] = '{
        '{12'd0,    1,  1'b1, CAL_WORD},
        '{12'd4095, 1,  1'b1, CAL_WORD},
        '{12'hAAA,  1,  1'b1, CAL_WORD},
        '{12'h555,  1,  1'b1, CAL_WORD},
        '{12'd2000, 46, 1'b1, CAL_WORD},
        '{12'd4095, 10, 1'b0, '0},
        '{12'd0,    10, 1'b0, '0},
        '{12'd2003, 3,  1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    gld_smp_if smp ();
    gld_res_if res ();

    gas_level_detector #(
        .WINDOW           (WINDOW),
        .BASELINE_SAMPLES (BASELINE_SAMPLES)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    t_sample thr_offset;
    t_sample hyst_width;
    t_total  cal_sum;
    int      cal_count;
    t_sample base_lvl;
    t_sample ring [WINDOW];
    int      ring_ptr;
    t_total  win_total;
    logic    gas_flag;

    t_result pending_words [$];

    int send_gap_pct;
    int recv_stall_pct;
    bit no_idle;

    int err_count     = 0;
    int words_checked = 0;
    int samples_sent  = 0;
    int alarms_seen   = 0;

    // expected result word for one accepted sample; advances the state
    function automatic t_result predict_gas_word(input t_sample value);
        t_result r;
        t_thr    thr;
        int      clear_lvl;
        r = '0;
        if (cal_count < BASELINE_SAMPLES) begin
            cal_sum   = cal_sum + t_total'(value);
            cal_count = cal_count + 1;
            if (cal_count == BASELINE_SAMPLES) begin
                base_lvl = t_sample'(cal_sum / BASELINE_SAMPLES);
                foreach (ring[i]) ring[i] = base_lvl;
                win_total = t_total'(base_lvl) * t_total'(WINDOW);
                ring_ptr  = 0;
            end
            r.calibrating = 1'b1;
            return r;
        end
        // replace the oldest window entry
        win_total      = win_total - t_total'(ring[ring_ptr]) + t_total'(value);
        ring[ring_ptr] = value;
        ring_ptr       = (ring_ptr == WINDOW - 1) ? 0 : ring_ptr + 1;
        r.average      = t_sample'(win_total / WINDOW);

        thr       = t_thr'(base_lvl) + t_thr'(thr_offset);
        // clear level may go negative, so compare signed
        clear_lvl = int'(thr) - int'(hyst_width);
        if (!gas_flag && r.average > thr) begin
            gas_flag       = 1'b1;
            r.alarm_raised = 1'b1;
        end else if (gas_flag && int'(r.average) < clear_lvl) begin
            gas_flag = 1'b0;
        end
        r.baseline_level  = base_lvl;
        r.threshold_level = thr;
        r.detected        = gas_flag;
        return r;
    endfunction

    // send one sample word; valid stays up into the next call unless a gap
    task automatic push_sample(input t_sample value, input logic typed,
                               input t_result want);
        t_result pred;
        while (!no_idle && $urandom_range(99) < send_gap_pct) begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid  <= 1'b1;
        smp.sample <= value;
        @(posedge clk);
        while (!smp.ready) @(posedge clk);
        pred = predict_gas_word(value);
        pending_words.push_back(typed ? want : pred);
        samples_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        smp.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic load_levels(input t_sample offset, input t_sample hyst);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_THR_OFFSET;
        cfg_data <= offset;
        @(posedge clk);
        thr_offset = offset;
        cfg_idx  <= CFG_HYST_WIDTH;
        cfg_data <= hyst;
        @(posedge clk);
        hyst_width = hyst;
        cfg_we <= 1'b0;
    endtask

    // gas episodes: plateaus near the trip level or anywhere on the scale,
    // with short bursts of raw noise in between
    task automatic run_phase(input int count);
        int left;
        int len;
        int kind;
        int level;
        int spread;
        int v;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(9);
            len  = (kind < 7) ? $urandom_range(30, 5) : $urandom_range(8, 1);
            if (len > left) len = left;
            no_idle = ($urandom_range(7) == 0);
            if (kind < 4)
                level = int'(base_lvl) + int'(thr_offset) + int'($urandom_range(800)) - 400;
            else
                level = $urandom_range(4095);
            spread = $urandom_range(64);
            repeat (len) begin
                if (kind < 7)
                    v = level + int'($urandom_range(2 * spread)) - spread;
                else
                    v = $urandom_range(4095);
                if (v < 0) v = 0;
                else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                push_sample(t_sample'(v), 1'b0, '0);
            end
            left -= len;
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls, field-by-field check against oldest entry
    initial begin : result_check
        t_result got;
        t_result want;
        logic    bad;
        res.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready) begin
                got.calibrating     = res.calibrating;
                got.average         = res.average;
                got.baseline_level  = res.baseline_level;
                got.threshold_level = res.threshold_level;
                got.detected        = res.detected;
                got.alarm_raised    = res.alarm_raised;
                if (pending_words.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("%0t: result word with nothing expected", $time);
                end else begin
                    want = pending_words.pop_front();
                    words_checked++;
                    if (got.alarm_raised) alarms_seen++;
                    bad = (got.calibrating !== want.calibrating) ||
                          (got.average !== want.average) ||
                          (got.baseline_level !== want.baseline_level) ||
                          (got.threshold_level !== want.threshold_level) ||
                          (got.detected !== want.detected) ||
                          (got.alarm_raised !== want.alarm_raised);
                    if (bad) begin
                        err_count++;
                        if (err_count <= MAX_SHOWN)
                            $display({"%0t word %0d: exp cal=%0b avg=%0d base=%0d thr=%0d ",
                                      "det=%0b alarm=%0b, got cal=%0b avg=%0d base=%0d ",
                                      "thr=%0d det=%0b alarm=%0b"},
                                     $time, words_checked,
                                     want.calibrating, want.average, want.baseline_level,
                                     want.threshold_level, want.detected, want.alarm_raised,
                                     got.calibrating, got.average, got.baseline_level,
                                     got.threshold_level, got.detected, got.alarm_raised);
                    end
                end
            end
            res.ready <= no_idle || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        t_sample offs;
        t_sample hyst;
        smp.valid  <= 1'b0;
        smp.sample <= '0;
        cfg_we     <= 1'b0;
        cfg_idx    <= CFG_THR_OFFSET;
        cfg_data   <= '0;
        rst_n      <= 1'b0;

        thr_offset = THR_OFFSET_RST;
        hyst_width = HYST_WIDTH_RST;
        cal_sum    = '0;
        cal_count  = 0;
        base_lvl   = '0;
        foreach (ring[i]) ring[i] = '0;
        ring_ptr   = 0;
        win_total  = '0;
        gas_flag   = 1'b0;

        send_gap_pct   = 18;
        recv_stall_pct = 75;
        no_idle        = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset register values
        foreach (stim_table[r])
            repeat (stim_table[r].reps)
                push_sample(stim_table[r].value, stim_table[r].typed, stim_table[r].want);
        drain_results();

        // random part, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                send_gap_pct   = 75;
                recv_stall_pct = 18;
            end else if (p == 6) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (p)
                0: begin offs = THR_OFFSET_RST; hyst = HYST_WIDTH_RST; end
                1: begin offs = '0;             hyst = '0;             end
                2: begin offs = 12'd4095;       hyst = 12'd4095;       end
                3: begin offs = '0;             hyst = 12'd4095;       end
                4: begin offs = 12'd4095;       hyst = '0;             end
                6: begin
                    offs = t_sample'($urandom_range(4095));
                    hyst = t_sample'($urandom_range(4095));
                end
                default: begin
                    offs = t_sample'($urandom_range(600));
                    hyst = t_sample'($urandom_range(300));
                end
            endcase
            load_levels(offs, hyst);
            run_phase(RANDOM_SAMPLES / NUM_PHASES);
            drain_results();
        end

        // wait out the pipeline for any stray words
        repeat (16) @(posedge clk);
        if (pending_words.size() != 0) begin
            $display("%0d result words never arrived", pending_words.size());
            err_count += pending_words.size();
        end

        $display("checked %0d result words from %0d samples (%0d calibration), %0d alarm edges",
                 words_checked, samples_sent, BASELINE_SAMPLES, alarms_seen);
        $display("ran %0d level settings incl. register extremes and a negative clear level",
                 NUM_PHASES + 1);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("run timed out with %0d words outstanding", pending_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
